@@ rtl/core/srmt_pkg.sv @@
// Shared types, widths and codes for the station ring membership table.
`default_nettype none

package srmt_pkg;

  // Table size and the widths that follow from it.
  localparam int SLOTS   = 5;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int START_W = ((IDX_W > 3) ? IDX_W : 3) + 1;

  // Fixed field widths of the ports.
  localparam int NET_W     = 32;
  localparam int NODE_W    = 48;
  localparam int SLOT_FW   = 3;
  localparam int COUNT_FW  = 3;
  localparam int REQ_W     = 2;
  localparam int REPLY_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 48;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request type codes.
  localparam logic [REQ_W-1:0] REQ_JOIN  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEAVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd3;

  // Reply codes.
  localparam logic [REPLY_W-1:0] REPLY_NONE   = 2'd0;
  localparam logic [REPLY_W-1:0] REPLY_ACCEPT = 2'd1;
  localparam logic [REPLY_W-1:0] REPLY_REJECT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_SLOT = 2'd2;

  // Classified command kinds.
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_JOIN,
    CMD_LEAVE,
    CMD_QUERY,
    CMD_LOAD
  } cmd_kind_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    cmd_kind_t         kind;
    logic [NET_W-1:0]  net;
    logic [NODE_W-1:0] node;
    logic [IDX_W-1:0]  slot;
    logic              in_use;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/station_ring_membership_table.sv @@
// Top level of the station ring membership table.
`default_nettype none

// Station ring membership table. Keeps five station entries (network number,
// node number, in-use bit) and serves join, disconnect, next-query and load
// requests, one result item per request item, in order. The front end
// classifies each item and puts it in a two-entry command queue; the
// execution unit then handles it in two steps: it updates the table from
// the queue head, then scans for the ring successor and counts the stations
// into the output register, waiting while that register holds an untaken
// result. It takes the next command only after that reply is loaded.
// The output register holds a result until it is taken while the queue keeps
// taking items. Configuration writes are always ready and take effect at once.
module station_ring_membership_table import srmt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [NET_W-1:0]     station_net,
  input  logic [NODE_W-1:0]    station_node,
  input  logic [SLOT_FW-1:0]   load_slot,
  input  logic                 load_in_use,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [REPLY_W-1:0]   reply_kind,
  output logic                 slot_claimed,
  output logic [SLOT_FW-1:0]   claimed_slot,
  output logic                 slot_freed,
  output logic                 next_valid,
  output logic [NET_W-1:0]     next_net,
  output logic [NODE_W-1:0]    next_node,
  output logic [COUNT_FW-1:0]  station_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic [NET_W-1:0]   own_net;
  logic [NODE_W-1:0]  own_node;
  logic [SLOT_FW-1:0] own_slot;

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_net  <= '0;
      own_node <= '0;
      own_slot <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_OWN_NET:  own_net  <= cfg_data[NET_W-1:0];
        CFG_OWN_NODE: own_node <= cfg_data[NODE_W-1:0];
        CFG_OWN_SLOT: own_slot <= cfg_data[SLOT_FW-1:0];
        default: begin
        end
      endcase
    end
  end

  srmt_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .station_net  (station_net),
    .station_node (station_node),
    .load_slot    (load_slot),
    .load_in_use  (load_in_use),
    .own_net      (own_net),
    .own_node     (own_node),
    .q_full       (q_full),
    .push         (q_push),
    .cmd          (q_in)
  );

  srmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  srmt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (q_pop),
    .own_slot      (own_slot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reply_kind    (reply_kind),
    .slot_claimed  (slot_claimed),
    .claimed_slot  (claimed_slot),
    .slot_freed    (slot_freed),
    .next_valid    (next_valid),
    .next_net      (next_net),
    .next_node     (next_node),
    .station_count (station_count)
  );

endmodule

`default_nettype wire

@@ rtl/core/srmt_front.sv @@
// Front end: accepts request items and classifies them into commands.
`default_nettype none

module srmt_front import srmt_pkg::*; (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [NET_W-1:0]    station_net,
  input  logic [NODE_W-1:0]   station_node,
  input  logic [SLOT_FW-1:0]  load_slot,
  input  logic                load_in_use,
  input  logic [NET_W-1:0]    own_net,
  input  logic [NODE_W-1:0]   own_node,
  input  logic                q_full,
  output logic                push,
  output cmd_t                cmd
);

  logic own_echo;
  logic load_ok;

  // An item is taken whenever the queue has room.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign own_echo = (station_net == own_net) && (station_node == own_node);
  assign load_ok  = int'(load_slot) < SLOTS;

  // Echoed joins and loads beyond the table become no-ops.
  always_comb begin
    cmd.net    = station_net;
    cmd.node   = station_node;
    cmd.slot   = IDX_W'(load_slot);
    cmd.in_use = load_in_use;
    case (req_type)
      REQ_JOIN:  cmd.kind = own_echo ? CMD_NOP : CMD_JOIN;
      REQ_LEAVE: cmd.kind = CMD_LEAVE;
      REQ_QUERY: cmd.kind = CMD_QUERY;
      REQ_LOAD:  cmd.kind = load_ok ? CMD_LOAD : CMD_NOP;
      default:   cmd.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/srmt_queue.sv @@
// Short command queue that decouples the front end from the execution unit.
`default_nettype none

module srmt_queue import srmt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/srmt_back.sv @@
// Execution unit: owns the station table, applies commands and forms results.
`default_nettype none

module srmt_back import srmt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  cmd_t                q_head,
  output logic                pop,
  input  logic [SLOT_FW-1:0]  own_slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [REPLY_W-1:0]  reply_kind,
  output logic                slot_claimed,
  output logic [SLOT_FW-1:0]  claimed_slot,
  output logic                slot_freed,
  output logic                next_valid,
  output logic [NET_W-1:0]    next_net,
  output logic [NODE_W-1:0]   next_node,
  output logic [COUNT_FW-1:0] station_count
);

  typedef enum logic [1:0] {
    ST_TAKE  = 2'b01,
    ST_REPLY = 2'b10
  } state_t;

  state_t state;

  // Station table.
  logic [NET_W-1:0]  net_tab  [SLOTS];
  logic [NODE_W-1:0] node_tab [SLOTS];
  logic [SLOTS-1:0]  in_use;

  // Command held between the update and the reply cycle.
  cmd_kind_t         cur_kind;
  logic [NET_W-1:0]  cur_net;
  logic [NODE_W-1:0] cur_node;
  logic              cur_claimed;
  logic [SLOT_FW-1:0] cur_cslot;
  logic              cur_freed;

  // Scan results.
  logic               free_hit;
  logic [IDX_W-1:0]   free_idx;
  logic               match_hit;
  logic [IDX_W-1:0]   match_idx;
  logic [START_W-1:0] own_plus;
  logic [START_W-1:0] start;
  logic               upper_hit;
  logic [IDX_W-1:0]   upper_idx;
  logic               succ_hit;
  logic [IDX_W-1:0]   any_idx;
  logic [IDX_W-1:0]   succ_idx;
  logic [CNT_W-1:0]   used;
  logic               want_next;
  logic               succ_is_req;
  logic               out_free;

  assign pop      = (state == ST_TAKE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  // Lowest free slot and first address match for the command at the queue head.
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (net_tab[i] == q_head.net && node_tab[i] == q_head.node) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  // Ring successor: first in-use slot at or after the start, else the first overall.
  assign own_plus = START_W'(own_slot) + 1'b1;
  assign start    = (own_plus >= START_W'(SLOTS)) ? '0 : own_plus;

  always_comb begin
    upper_hit = 1'b0;
    upper_idx = '0;
    succ_hit  = 1'b0;
    any_idx   = '0;
    used      = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (in_use[i]) begin
        succ_hit = 1'b1;
        any_idx  = IDX_W'(i);
        used     = used + 1'b1;
        if (START_W'(i) >= start) begin
          upper_hit = 1'b1;
          upper_idx = IDX_W'(i);
        end
      end
    end
    succ_idx = upper_hit ? upper_idx : any_idx;
  end

  assign want_next   = (cur_kind == CMD_JOIN) || (cur_kind == CMD_QUERY);
  assign succ_is_req = (net_tab[succ_idx] == cur_net) && (node_tab[succ_idx] == cur_node);

  // Sequencer, table updates and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TAKE;
      in_use    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        net_tab[i]  <= '0;
        node_tab[i] <= '0;
      end
    end else begin
      // A taken result item clears unless the reply cycle loads a new one.
      if (out_valid && !out_stall && state != ST_REPLY) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_TAKE: begin
          if (q_valid) begin
            cur_kind    <= q_head.kind;
            cur_net     <= q_head.net;
            cur_node    <= q_head.node;
            cur_claimed <= (q_head.kind == CMD_JOIN) && free_hit;
            cur_cslot   <= ((q_head.kind == CMD_JOIN) && free_hit) ? SLOT_FW'(free_idx) : '0;
            cur_freed   <= (q_head.kind == CMD_LEAVE) && match_hit;
            case (q_head.kind)
              CMD_JOIN: begin
                if (free_hit) begin
                  net_tab[free_idx]  <= q_head.net;
                  node_tab[free_idx] <= q_head.node;
                  in_use[free_idx]   <= 1'b1;
                end
              end
              CMD_LEAVE: begin
                if (match_hit) begin
                  in_use[match_idx] <= 1'b0;
                end
              end
              CMD_LOAD: begin
                net_tab[q_head.slot]  <= q_head.net;
                node_tab[q_head.slot] <= q_head.node;
                in_use[q_head.slot]   <= q_head.in_use;
              end
              default: begin
              end
            endcase
            state <= ST_REPLY;
          end
        end
        ST_REPLY: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            slot_claimed  <= cur_claimed;
            claimed_slot  <= cur_cslot;
            slot_freed    <= cur_freed;
            station_count <= COUNT_FW'(used);
            if (want_next && succ_hit) begin
              next_valid <= 1'b1;
              next_net   <= net_tab[succ_idx];
              next_node  <= node_tab[succ_idx];
            end else begin
              next_valid <= 1'b0;
              next_net   <= '0;
              next_node  <= '0;
            end
            if (cur_kind == CMD_JOIN && succ_hit && succ_is_req) begin
              reply_kind <= cur_claimed ? REPLY_ACCEPT : REPLY_REJECT;
            end else begin
              reply_kind <= REPLY_NONE;
            end
            state <= ST_TAKE;
          end
        end
        default: begin
          state <= ST_TAKE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/srmt_checker.sv @@
// Port-level checker for the station ring membership table and its bind.
`default_nettype none

module srmt_checker import srmt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [REPLY_W-1:0]   reply_kind,
  input logic                 slot_claimed,
  input logic [SLOT_FW-1:0]   claimed_slot,
  input logic                 slot_freed,
  input logic                 next_valid,
  input logic [NET_W-1:0]     next_net,
  input logic [NODE_W-1:0]    next_node,
  input logic [COUNT_FW-1:0]  station_count
);

  // A stalled result item holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reply_kind) && $stable(next_net)
      && $stable(next_node) && $stable(station_count) && $stable(claimed_slot))
    else $error("result item changed while stalled");

  // A reply is only given when a successor was found.
  a_reply_succ: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_kind != REPLY_NONE |-> next_valid)
    else $error("reply without a ring successor");

  // An accepted reply needs a claimed slot, a rejected one needs none.
  a_reply_claim: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reply_kind == REPLY_ACCEPT || reply_kind == REPLY_REJECT)
      |-> slot_claimed == (reply_kind == REPLY_ACCEPT))
    else $error("reply kind disagrees with slot claim");

  // Fields that the request did not produce read as zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (slot_claimed || claimed_slot == '0)
      && (next_valid || (next_net == '0 && next_node == '0)))
    else $error("unproduced result field not zero");

  // A request never both claims and frees a slot.
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(slot_claimed && slot_freed))
    else $error("claim and free in one result item");

endmodule

bind station_ring_membership_table srmt_checker u_srmt_checker (.*);

`default_nettype wire

@@ sim/station_ring_membership_table_tb.sv @@
// Self-checking testbench for the station ring membership table.
module station_ring_membership_table_tb;
  import srmt_pkg::*;

  localparam int POOL_SIZE    = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // One request item as driven on the input channel.
  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [NET_W-1:0]   net_num;
    logic [NODE_W-1:0]  node_num;
    logic [SLOT_FW-1:0] lslot;
    logic               luse;
  } request_t;

  // One result item, in port order.
  typedef struct packed {
    logic [REPLY_W-1:0]  reply;
    logic                claimed;
    logic [SLOT_FW-1:0]  cslot;
    logic                freed;
    logic                nvalid;
    logic [NET_W-1:0]    nnet;
    logic [NODE_W-1:0]   nnode;
    logic [COUNT_FW-1:0] count;
  } outcome_t;

  // Tracks the station table and the outcomes still owed by the block.
  class ring_table_tracker;
    logic [NET_W-1:0]   own_net;
    logic [NODE_W-1:0]  own_node;
    logic [SLOT_FW-1:0] own_slot;
    logic [NET_W-1:0]   net_tab [SLOTS];
    logic [NODE_W-1:0]  node_tab [SLOTS];
    logic               used [SLOTS];
    outcome_t           owed_outcomes [$];
    int mismatches, checked, joins, echoes, accepts, rejects, frees, loads, queries;

    function new();
      own_net  = '0;
      own_node = '0;
      own_slot = '0;
      for (int i = 0; i < SLOTS; i++) begin
        net_tab[i]  = '0;
        node_tab[i] = '0;
        used[i]     = 1'b0;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_OWN_NET:  own_net  = data[NET_W-1:0];
        CFG_OWN_NODE: own_node = data[NODE_W-1:0];
        CFG_OWN_SLOT: own_slot = data[SLOT_FW-1:0];
        default: ;
      endcase
    endfunction

    // First in-use slot after our own, wrapping; our own slot comes last.
    function int successor();
      int start;
      int s;
      start = own_slot + 1;
      if (start >= SLOTS) start = 0;
      for (int k = 0; k < SLOTS; k++) begin
        s = (start + k) % SLOTS;
        if (used[s]) return s;
      end
      return -1;
    endfunction

    function int pending();
      return owed_outcomes.size();
    endfunction

    // Apply an accepted request to the table and queue its outcome.
    function void note_request(request_t r);
      outcome_t o;
      logic want_next;
      logic found;
      int s;
      int n;
      o = '0;
      want_next = 1'b0;
      found = 1'b0;
      case (r.kind)
        REQ_JOIN: begin
          joins++;
          if (r.net_num == own_net && r.node_num == own_node) begin
            echoes++;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!found && !used[i]) begin
                net_tab[i]  = r.net_num;
                node_tab[i] = r.node_num;
                used[i]     = 1'b1;
                found       = 1'b1;
                o.claimed   = 1'b1;
                o.cslot     = SLOT_FW'(i);
              end
            end
            want_next = 1'b1;
          end
        end
        REQ_LEAVE: begin
          // The address match ignores the in-use bit.
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && net_tab[i] == r.net_num && node_tab[i] == r.node_num) begin
              used[i] = 1'b0;
              found   = 1'b1;
              o.freed = 1'b1;
              frees++;
            end
          end
        end
        REQ_QUERY: begin
          queries++;
          want_next = 1'b1;
        end
        default: begin
          loads++;
          if (r.lslot < SLOTS) begin
            net_tab[r.lslot]  = r.net_num;
            node_tab[r.lslot] = r.node_num;
            used[r.lslot]     = r.luse;
          end
        end
      endcase

      if (want_next) begin
        s = successor();
        if (s >= 0) begin
          o.nvalid = 1'b1;
          o.nnet   = net_tab[s];
          o.nnode  = node_tab[s];
          if (r.kind == REQ_JOIN && o.nnet == r.net_num && o.nnode == r.node_num) begin
            o.reply = o.claimed ? REPLY_ACCEPT : REPLY_REJECT;
            if (o.claimed) accepts++;
            else rejects++;
          end
        end
      end

      n = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (used[i]) n++;
      end
      o.count = COUNT_FW'(n);
      owed_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare a result item with the oldest owed outcome.
    function void check_result(outcome_t got);
      outcome_t want;
      if (owed_outcomes.size() == 0) begin
        $error("result item arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = owed_outcomes.pop_front();
      checked++;
      compare_field("reply_kind", 64'(want.reply), 64'(got.reply));
      compare_field("slot_claimed", 64'(want.claimed), 64'(got.claimed));
      compare_field("claimed_slot", 64'(want.cslot), 64'(got.cslot));
      compare_field("slot_freed", 64'(want.freed), 64'(got.freed));
      compare_field("next_valid", 64'(want.nvalid), 64'(got.nvalid));
      compare_field("next_net", 64'(want.nnet), 64'(got.nnet));
      compare_field("next_node", 64'(want.nnode), 64'(got.nnode));
      compare_field("station_count", 64'(want.count), 64'(got.count));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type;
  logic [NET_W-1:0]     station_net;
  logic [NODE_W-1:0]    station_node;
  logic [SLOT_FW-1:0]   load_slot;
  logic                 load_in_use;
  logic                 out_valid;
  logic                 out_stall;
  logic [REPLY_W-1:0]   reply_kind;
  logic                 slot_claimed;
  logic [SLOT_FW-1:0]   claimed_slot;
  logic                 slot_freed;
  logic                 next_valid;
  logic [NET_W-1:0]     next_net;
  logic [NODE_W-1:0]    next_node;
  logic [COUNT_FW-1:0]  station_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  ring_table_tracker tracker;
  logic [NET_W-1:0]  pool_net [POOL_SIZE];
  logic [NODE_W-1:0] pool_node [POOL_SIZE];
  logic              idle_on;
  int                cycles;

  station_ring_membership_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .station_net  (station_net),
    .station_node (station_node),
    .load_slot    (load_slot),
    .load_in_use  (load_in_use),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reply_kind   (reply_kind),
    .slot_claimed (slot_claimed),
    .claimed_slot (claimed_slot),
    .slot_freed   (slot_freed),
    .next_valid   (next_valid),
    .next_net     (next_net),
    .next_node    (next_node),
    .station_count(station_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle count and the run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    cycles = 0;
    wait (cycles >= CYCLE_LIMIT);
    $display("Run limit of %0d cycles reached with %0d results outstanding.",
             CYCLE_LIMIT, tracker.pending());
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver stalls in random bursts while idling is enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result item is checked.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_result({reply_kind, slot_claimed, claimed_slot, slot_freed, next_valid,
                            next_net, next_node, station_count});
    end
  end

  function automatic request_t make_request(logic [REQ_W-1:0] kind, logic [NET_W-1:0] net_num,
                                            logic [NODE_W-1:0] node_num,
                                            logic [SLOT_FW-1:0] lslot, logic luse);
    request_t r;
    r.kind     = kind;
    r.net_num  = net_num;
    r.node_num = node_num;
    r.lslot    = lslot;
    r.luse     = luse;
    return r;
  endfunction

  // Mostly known addresses so joins and disconnects meet, some own echoes, some noise.
  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.kind = REQ_JOIN;
    else if (pick < 65) r.kind = REQ_LEAVE;
    else if (pick < 80) r.kind = REQ_QUERY;
    else r.kind = REQ_LOAD;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.net_num  = tracker.own_net;
      r.node_num = tracker.own_node;
    end else if (pick < 80) begin
      pick = $urandom_range(0, POOL_SIZE - 1);
      r.net_num  = pool_net[pick];
      r.node_num = pool_node[pick];
    end else begin
      r.net_num  = $urandom();
      r.node_num = {16'($urandom()), 32'($urandom())};
    end
    r.lslot = SLOT_FW'($urandom_range(0, 7));
    r.luse  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input request_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= r.kind;
    station_net  <= r.net_num;
    station_node <= r.node_num;
    load_slot    <= r.lslot;
    load_in_use  <= r.luse;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(r);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_register(idx, data);
    @(negedge clk);
  endtask

  // Unused upper data bits carry noise; the block keeps only the field width.
  task automatic configure(input logic [NET_W-1:0] net_num, input logic [NODE_W-1:0] node_num,
                           input logic [SLOT_FW-1:0] slot);
    write_register(CFG_OWN_NET, {16'($urandom()), net_num});
    write_register(CFG_OWN_NODE, node_num);
    write_register(CFG_OWN_SLOT, {45'($urandom()), slot});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [NET_W-1:0]   phase_net [PHASES];
    logic [NODE_W-1:0]  phase_node [PHASES];
    logic [SLOT_FW-1:0] phase_slot [PHASES];

    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_JOIN;
    station_net  = '0;
    station_node = '0;
    load_slot    = '0;
    load_in_use  = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_OWN_NET;
    cfg_data     = '0;
    idle_on      = 1'b0;
    tracker      = new();

    // Address pool: both extremes mixed, then random stations.
    pool_net[0] = '0;
    pool_node[0] = '0;
    pool_net[1] = '1;
    pool_node[1] = '0;
    pool_net[2] = '0;
    pool_node[2] = '1;
    for (int i = 3; i < POOL_SIZE; i++) begin
      pool_net[i]  = $urandom();
      pool_node[i] = {16'($urandom()), 32'($urandom())};
    end

    // Own address and slot per phase, out-of-range slots included.
    phase_net[0] = '0;
    phase_node[0] = '0;
    phase_slot[0] = 3'd0;
    phase_net[1] = pool_net[3];
    phase_node[1] = pool_node[3];
    phase_slot[1] = 3'd4;
    phase_net[2] = $urandom();
    phase_node[2] = {16'($urandom()), 32'($urandom())};
    phase_slot[2] = 3'd5;
    phase_net[3] = '1;
    phase_node[3] = '0;
    phase_slot[3] = 3'd7;
    phase_net[4] = pool_net[5];
    phase_node[4] = pool_node[5];
    phase_slot[4] = 3'd1;
    phase_net[5] = $urandom();
    phase_node[5] = {16'($urandom()), 32'($urandom())};
    phase_slot[5] = 3'd3;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: own address all ones, own slot 2.
    configure('1, '1, 3'd2);
    send_request(make_request(REQ_QUERY, '0, '0, 3'd0, 1'b0));   // empty ring
    send_request(make_request(REQ_JOIN, '1, '1, 3'd7, 1'b1));     // own echo
    send_request(make_request(REQ_JOIN, pool_net[1], pool_node[1], 3'd0, 1'b0));
    send_request(make_request(REQ_JOIN, pool_net[2], pool_node[2], 3'd0, 1'b0));
    send_request(make_request(REQ_JOIN, pool_net[3], pool_node[3], 3'd0, 1'b0));
    send_request(make_request(REQ_JOIN, pool_net[4], pool_node[4], 3'd0, 1'b0));
    send_request(make_request(REQ_JOIN, pool_net[5], pool_node[5], 3'd0, 1'b0));
    send_request(make_request(REQ_JOIN, pool_net[6], pool_node[6], 3'd0, 1'b0)); // full
    send_request(make_request(REQ_JOIN, pool_net[4], pool_node[4], 3'd0, 1'b0)); // rejected
    send_request(make_request(REQ_QUERY, '1, '1, 3'd7, 1'b1));
    send_request(make_request(REQ_LEAVE, pool_net[4], pool_node[4], 3'd0, 1'b0));
    send_request(make_request(REQ_LEAVE, pool_net[7], pool_node[7], 3'd0, 1'b0)); // no match
    send_request(make_request(REQ_LOAD, pool_net[7], pool_node[7], 3'd7, 1'b1));  // ignored
    send_request(make_request(REQ_LOAD, pool_net[7], pool_node[7], 3'd5, 1'b1));  // ignored
    send_request(make_request(REQ_LOAD, '0, '0, 3'd4, 1'b0));
    send_request(make_request(REQ_LEAVE, '0, '0, 3'd0, 1'b0));   // matches a free slot
    send_request(make_request(REQ_LOAD, pool_net[6], pool_node[6], 3'd3, 1'b1));
    send_request(make_request(REQ_QUERY, '0, '0, 3'd0, 1'b0));
    send_request(make_request(REQ_LEAVE, pool_net[1], pool_node[1], 3'd0, 1'b0));
    send_request(make_request(REQ_LEAVE, pool_net[2], pool_node[2], 3'd0, 1'b0));
    send_request(make_request(REQ_LEAVE, pool_net[3], pool_node[3], 3'd0, 1'b0));
    send_request(make_request(REQ_LEAVE, pool_net[6], pool_node[6], 3'd0, 1'b0));
    send_request(make_request(REQ_QUERY, '1, '1, 3'd7, 1'b1));
    drain();

    // Random phases, each with its own station identity; the third and the last run without idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      configure(phase_net[ph], phase_node[ph], phase_slot[ph]);
      idle_on = (ph != 2 && ph != PHASES - 1);
      repeat (PHASE_ITEMS) send_request(random_request());
      drain();
    end
    idle_on = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d results: %0d joins, %0d disconnect hits, %0d next queries, %0d loads.",
             tracker.checked, tracker.joins, tracker.frees, tracker.queries, tracker.loads);
    $display("Joins gave %0d own-address echoes, %0d accepted and %0d rejected replies.",
             tracker.echoes, tracker.accepts, tracker.rejects);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ station_ring_membership_table.f @@
rtl/core/srmt_pkg.sv
rtl/core/srmt_front.sv
rtl/core/srmt_queue.sv
rtl/core/srmt_back.sv
rtl/core/station_ring_membership_table.sv
rtl/core/srmt_checker.sv
sim/station_ring_membership_table_tb.sv
